[src/ssd_pkg.sv]
package ssd_pkg;

   localparam int ValueWidth = 14;
   localparam int DigitCount = 4;
   localparam int DigitWidth = 4;
   localparam int BcdWidth = DigitCount * DigitWidth;
   localparam int StepCount = ValueWidth;
   localparam int StepCntWidth = $clog2(StepCount);
   localparam int FrameLen = 64;
   localparam int FrameCntWidth = $clog2(FrameLen);
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [ValueWidth-1:0] ValueMax = ValueWidth'(9999);
   localparam logic [StepCntWidth-1:0] StepLast = StepCntWidth'(StepCount - 1);
   localparam logic [FrameCntWidth-1:0] FrameLast = FrameCntWidth'(FrameLen - 1);
   localparam logic [QueueCntWidth-1:0] QueueFull = QueueCntWidth'(QueueDepth);

   typedef logic [DigitWidth-1:0] bcd_digit_type;
   // index DigitCount-1 holds the thousands digit
   typedef bcd_digit_type [DigitCount-1:0] digits_type;

   typedef struct packed {
      logic       valid;
      digits_type digits;
   } entry_beat_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CONV,
      FE_PUSH
   } fe_state_type;

   // common-cathode codes, bit 0 = segment a
   function automatic logic [7:0] seg_code(input bcd_digit_type digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'h3f;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5b;
         4'd3: code = 8'h4f;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6d;
         4'd6: code = 8'h7d;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7f;
         4'd9: code = 8'h6f;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

[src/ssd_if.sv]
interface ssd_req_if;
   logic                             valid;
   logic                             ready;
   logic [ssd_pkg::ValueWidth-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface ssd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] digit_select;
   logic       serial_bit;
   logic       blank_phase;
   logic       latch;
   logic       last;

   modport source (output valid, output digit_select, output serial_bit,
                   output blank_phase, output latch, output last, input ready);
   modport sink (input valid, input digit_select, input serial_bit,
                 input blank_phase, input latch, input last, output ready);
endinterface

[src/ssd_front.sv]
module ssd_front (
   input  logic                   clock,
   input  logic                   reset,
   ssd_req_if.sink                req_chan,
   output ssd_pkg::entry_beat_type push,
   input  logic                   push_ready
);

   ssd_pkg::fe_state_type state_ff, state_in;
   logic [ssd_pkg::StepCntWidth-1:0] step_ff, step_in;
   logic [ssd_pkg::ValueWidth-1:0]   bin_ff, bin_in;
   ssd_pkg::digits_type              bcd_ff, bcd_in;
   ssd_pkg::digits_type              adj;
   logic [ssd_pkg::ValueWidth-1:0]   sat_value;
   logic                             load, shift;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssd_pkg::FE_IDLE: begin
            if (req_chan.valid) state_in = ssd_pkg::FE_CONV;
         end
         ssd_pkg::FE_CONV: begin
            if (step_ff == ssd_pkg::StepLast) state_in = ssd_pkg::FE_PUSH;
         end
         ssd_pkg::FE_PUSH: begin
            if (push_ready) state_in = ssd_pkg::FE_IDLE;
         end
         default: state_in = ssd_pkg::FE_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      push.valid = 1'b0;
      push.digits = bcd_ff;
      shift = 1'b0;
      case (state_ff)
         ssd_pkg::FE_IDLE: req_chan.ready = 1'b1;
         ssd_pkg::FE_CONV: shift = 1'b1;
         ssd_pkg::FE_PUSH: push.valid = 1'b1;
         default: req_chan.ready = 1'b0;
      endcase
   end

   assign load = req_chan.valid && req_chan.ready;
   assign sat_value = (req_chan.value > ssd_pkg::ValueMax) ? ssd_pkg::ValueMax
                                                           : req_chan.value;

   // shift-and-add-3: correct each digit, then move one binary bit in
   always_comb begin
      for (int i = 0; i < ssd_pkg::DigitCount; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      step_in = step_ff;
      if (load) begin
         bin_in = sat_value;
         bcd_in = '0;
         step_in = '0;
      end else if (shift) begin
         bcd_in = {adj[ssd_pkg::DigitCount-1][ssd_pkg::DigitWidth-2:0],
                   adj[ssd_pkg::DigitCount-2:0], bin_ff[ssd_pkg::ValueWidth-1]};
         bin_in = {bin_ff[ssd_pkg::ValueWidth-2:0], 1'b0};
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssd_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      step_ff <= step_in;
   end

endmodule

[src/ssd_queue.sv]
module ssd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  ssd_pkg::entry_beat_type push,
   output logic                    push_ready,
   output ssd_pkg::entry_beat_type head,
   input  logic                    pop
);

   ssd_pkg::digits_type entries_ff [ssd_pkg::QueueDepth];
   logic [ssd_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::QueueCntWidth-1:0] count_ff, count_in;
   logic push_fire, pop_fire;

   assign push_ready = (count_ff != ssd_pkg::QueueFull);
   assign push_fire = push.valid && push_ready;
   assign pop_fire = pop && head.valid;
   assign head.valid = (count_ff != '0);
   assign head.digits = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + ssd_pkg::QueueCntWidth'(push_fire)
                          - ssd_pkg::QueueCntWidth'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push_fire) entries_ff[wr_ptr_ff] <= push.digits;
   end

endmodule

[src/ssd_back.sv]
module ssd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ssd_pkg::entry_beat_type head,
   output logic                    pop,
   ssd_rsp_if.source               rsp_chan
);

   logic [ssd_pkg::FrameCntWidth-1:0] cnt_ff, cnt_in;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] digit_select_ff, digit_select_in;
   logic       serial_bit_ff, serial_bit_in;
   logic       blank_phase_ff, blank_phase_in;
   logic       latch_ff, latch_in;
   logic       last_ff, last_in;
   logic       advance;
   logic [1:0] digit_pos;
   logic [2:0] bit_pos;
   logic [7:0] code;

   assign advance = head.valid && (!out_valid_ff || rsp_chan.ready);
   assign pop = advance && (cnt_ff == ssd_pkg::FrameLast);

   assign digit_pos = cnt_ff[5:4];
   assign bit_pos = cnt_ff[2:0];
   // digits are stored ones first, sent thousands first
   assign code = ssd_pkg::seg_code(head.digits[~digit_pos]);

   always_comb begin
      cnt_in = advance ? cnt_ff + 1'b1 : cnt_ff;
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      digit_select_in = digit_pos;
      blank_phase_in = cnt_ff[3];
      serial_bit_in = cnt_ff[3] ? 1'b0 : code[3'd7 - bit_pos];
      latch_in = (bit_pos == 3'd7);
      last_in = (cnt_ff == ssd_pkg::FrameLast);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         digit_select_ff <= digit_select_in;
         serial_bit_ff <= serial_bit_in;
         blank_phase_ff <= blank_phase_in;
         latch_ff <= latch_in;
         last_ff <= last_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.digit_select = digit_select_ff;
   assign rsp_chan.serial_bit = serial_bit_ff;
   assign rsp_chan.blank_phase = blank_phase_ff;
   assign rsp_chan.latch = latch_ff;
   assign rsp_chan.last = last_ff;

`ifndef SYNTHESIS
   a_last_closes_blank: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && last_ff |-> latch_ff && blank_phase_ff && digit_select_ff == 2'd3)
      else $error("frame end not on final blanking bit");

   a_blank_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && blank_phase_ff |-> !serial_bit_ff)
      else $error("nonzero bit in blanking byte");

   a_digit_follows_count: assert property (@(posedge clock) disable iff (reset)
      advance |=> digit_select_ff == $past(cnt_ff[5:4]))
      else $error("digit select out of step with frame count");

   a_pop_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      pop |=> cnt_ff == '0)
      else $error("frame count not wrapped at entry release");
`endif

endmodule

[src/seven_segment_serial_display_driver.sv]
// channel   dir  handshake             payload
// req_chan  in   valid/ready           value[13:0]
// rsp_chan  out  valid/ready           digit_select[1:0] serial_bit blank_phase latch last
//
// Each value gives a frame of 64 beats, one per cycle while the sink is ready;
// the serializer in the back end, one bit per cycle, sets that rate.
// Per value the front end goes through load, 14 conversion steps and push,
// and runs ahead of the serializer through a two-entry queue.
// Reset is synchronous and clears only control state.
// A stalled sink holds the output register; the front end keeps converting
// until the queue fills.
module seven_segment_serial_display_driver (
   input logic        clock,
   input logic        reset,
   ssd_req_if.sink    req_chan,
   ssd_rsp_if.source  rsp_chan
);

   ssd_pkg::entry_beat_type push;
   ssd_pkg::entry_beat_type head;
   logic push_ready;
   logic pop;

   // saturate, then convert to four BCD digits
   ssd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .push_ready (push_ready)
   );

   // hold converted digits until the serializer frees its slot
   ssd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   // walk the frame: per digit, segment byte MSB first, then a blank byte;
   // drop the queue head after the last beat
   ssd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[tb/tb_seven_segment_serial_display_driver.sv]
`timescale 1ns / 100ps

module tb_seven_segment_serial_display_driver;

   // one serial shift clock as the display sees it
   typedef struct packed {
      logic [1:0] digit_select;
      logic       serial_bit;
      logic       blank_phase;
      logic       latch;
      logic       last;
   } shift_beat_type;

   // common-cathode patterns for digits 9 down to 0, bit 0 = segment a
   localparam logic [9:0][7:0] DigitPattern = {
      8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };
   localparam int ShownMax = 9999;
   localparam int BeatsPerDigit = 16;
   localparam int BitsPerByte = 8;
   localparam int ErrorReportMax = 10;
   localparam int LongHoldCycles = 300;
   localparam int SettleCycles = 64;

   logic clock;
   logic reset;

   ssd_req_if req_bus ();
   ssd_rsp_if rsp_bus ();

   seven_segment_serial_display_driver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shift beats still owed by the block, oldest first
   shift_beat_type owed_beats[$];

   bit sender_idles;
   bit receiver_idles;
   int hold_request;
   int error_count;
   int values_sent;
   int saturated_sent;
   int beats_checked;

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // Expand one value into its 64-beat frame: per digit, thousands first,
   // the segment byte MSB first followed by an all-zero blanking byte.
   function automatic void queue_display_frame(
      input logic [ssd_pkg::ValueWidth-1:0] value);
      int shown;
      int digit_value [4];
      logic [7:0] pattern;
      shift_beat_type beat;
      int pos;
      shown = (int'(value) > ShownMax) ? ShownMax : int'(value);
      digit_value[0] = shown / 1000;
      digit_value[1] = (shown / 100) % 10;
      digit_value[2] = (shown / 10) % 10;
      digit_value[3] = shown % 10;
      for (int k = 0; k < ssd_pkg::FrameLen; k++) begin
         pos = k % BeatsPerDigit;
         pattern = DigitPattern[digit_value[k / BeatsPerDigit]];
         beat.digit_select = 2'(k / BeatsPerDigit);
         beat.blank_phase = (pos >= BitsPerByte);
         beat.serial_bit = beat.blank_phase ? 1'b0
                           : pattern[BitsPerByte - 1 - pos % BitsPerByte];
         beat.latch = (pos % BitsPerByte == BitsPerByte - 1);
         beat.last = (k == ssd_pkg::FrameLen - 1);
         owed_beats.push_back(beat);
      end
   endfunction

   task automatic report_error(input string what, input shift_beat_type want,
                               input shift_beat_type seen);
      if (error_count < ErrorReportMax) begin
         $display("%0t: %s: expected sel=%0d bit=%0d blank=%0d latch=%0d last=%0d",
                  $time, what, want.digit_select, want.serial_bit, want.blank_phase,
                  want.latch, want.last);
         $display("%0t: %s:   actual sel=%0d bit=%0d blank=%0d latch=%0d last=%0d",
                  $time, what, seen.digit_select, seen.serial_bit, seen.blank_phase,
                  seen.latch, seen.last);
      end
      error_count++;
   endtask

   // Offer one value after a random gap and hold it until the block takes it.
   // Valid is only lowered when a gap is drawn, so back-to-back beats keep it high.
   task automatic send_value(input logic [ssd_pkg::ValueWidth-1:0] value);
      int gap;
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      // beat accepted at this edge
      queue_display_frame(value);
      values_sent++;
      if (int'(value) > ShownMax) saturated_sent++;
   endtask

   // Drop valid and hold off until every owed beat has come back.
   task automatic wait_for_frames;
      req_bus.valid <= 1'b0;
      while (owed_beats.size() != 0) @(posedge clock);
   endtask

   // Field extremes, mixed digits in each position, and values above range.
   task automatic test_directed_values;
      logic [ssd_pkg::ValueWidth-1:0] picks [$];
      picks = '{14'd0, 14'd1, 14'd9, 14'd10, 14'd99, 14'd100, 14'd999, 14'd1000,
                14'd1234, 14'd5678, 14'd9000, 14'd8080, 14'd4567, 14'd3210,
                14'd9999, 14'd10000, 14'd16383, 14'h2aaa, 14'h1555, 14'd7096};
      foreach (picks[i]) send_value(picks[i]);
   endtask

   // Stall the display side for a long stretch while values keep coming, so the
   // internal queue fills and the input stalls.
   task automatic test_output_hold;
      sender_idles = 1'b0;
      hold_request = LongHoldCycles;
      for (int i = 0; i < 8; i++)
         send_value(ssd_pkg::ValueWidth'($urandom_range(0, ShownMax)));
      sender_idles = 1'b1;
   endtask

   // Pause the sender until the pipeline is empty, then restart from idle.
   task automatic test_drain_pause;
      for (int i = 0; i < 3; i++)
         send_value(ssd_pkg::ValueWidth'($urandom_range(0, 16383)));
      wait_for_frames();
      for (int i = 0; i < 3; i++)
         send_value(ssd_pkg::ValueWidth'($urandom_range(0, 16383)));
   endtask

   // Mostly in-range values, some above range; idling changes every stretch,
   // with one stretch where neither side idles.
   task automatic test_random_values;
      int pick;
      logic [ssd_pkg::ValueWidth-1:0] value;
      for (int i = 0; i < 80; i++) begin
         case ((i / 16) % 4)
            0: begin sender_idles = 1'b1; receiver_idles = 1'b1; end
            1: begin sender_idles = 1'b0; receiver_idles = 1'b0; end
            2: begin sender_idles = 1'b1; receiver_idles = 1'b0; end
            default: begin sender_idles = 1'b0; receiver_idles = 1'b1; end
         endcase
         pick = $urandom_range(0, 9);
         if (pick < 7)
            value = ssd_pkg::ValueWidth'($urandom_range(0, ShownMax));
         else if (pick < 8)
            value = ssd_pkg::ValueWidth'($urandom_range(ShownMax + 1, 16383));
         else
            value = ssd_pkg::ValueWidth'($urandom);
         send_value(value);
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Display side: random stalls per beat, plus a long hold when requested.
   initial begin
      int stall;
      int hold;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = receiver_idles ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Compare every accepted shift beat against the oldest owed one.
   always @(posedge clock) begin : check_shift_beats
      shift_beat_type seen;
      shift_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.digit_select = rsp_bus.digit_select;
         seen.serial_bit = rsp_bus.serial_bit;
         seen.blank_phase = rsp_bus.blank_phase;
         seen.latch = rsp_bus.latch;
         seen.last = rsp_bus.last;
         if (owed_beats.size() == 0) begin
            want = '0;
            report_error("unexpected beat", want, seen);
         end else begin
            want = owed_beats.pop_front();
            if (seen.digit_select !== want.digit_select ||
                seen.serial_bit !== want.serial_bit ||
                seen.blank_phase !== want.blank_phase ||
                seen.latch !== want.latch ||
                seen.last !== want.last)
               report_error("beat mismatch", want, seen);
            beats_checked++;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      hold_request = 0;
      error_count = 0;
      values_sent = 0;
      saturated_sent = 0;
      beats_checked = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_output_hold();
      test_drain_pause();
      test_random_values();

      // drain, then give the block time to show any stray beats
      wait_for_frames();
      repeat (SettleCycles) @(posedge clock);
      if (owed_beats.size() != 0) begin
         $display("%0d shift beats never arrived", owed_beats.size());
         error_count++;
      end

      $display("ran %0d display values (%0d above range), %0d shift beats compared",
               values_sent, saturated_sent, beats_checked);
      $display("included a %0d-cycle output hold and a full drain pause, %0d errors",
               LongHoldCycles, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
